// ===== sv/fsrb_pkg.sv =====
`default_nettype none
package fsrb_pkg;

  localparam int FlowW    = 16;
  localparam int DiffW    = FlowW + 1;
  localparam int GradW    = FlowW + 2;
  localparam int SqW      = 2 * GradW;
  localparam int RootW    = SqW / 2;
  localparam int RemW     = RootW + 2;
  localparam int TrW      = FlowW + 1;
  localparam int PeakW    = 18;
  localparam int BandW    = 4;
  localparam int NumBands = 8;
  localparam int SelW     = $clog2(NumBands);
  localparam int ColW     = 8;
  localparam int IdxW     = 4;
  localparam int NumCells = RootW;
  localparam int GradStages = 4;

  localparam logic [BandW-1:0] BandNone = BandW'(NumBands);

  typedef logic [NumBands-1:0][PeakW-1:0] thr_t;

  typedef struct packed {
    logic signed [FlowW-1:0] above_vx;
    logic signed [FlowW-1:0] above_vy;
    logic signed [FlowW-1:0] below_vx;
    logic signed [FlowW-1:0] below_vy;
    logic signed [FlowW-1:0] left_vx;
    logic signed [FlowW-1:0] left_vy;
    logic signed [FlowW-1:0] right_vx;
    logic signed [FlowW-1:0] right_vy;
  } flows_t;

  typedef struct packed {
    logic [SqW-1:0]   rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [TrW-1:0]   trabs;
  } sq_t;

  typedef struct packed {
    logic [ColW-1:0] blue;
    logic [ColW-1:0] green;
    logic [ColW-1:0] red;
  } colour_t;

  function automatic colour_t band_colour(logic [BandW-1:0] band);
    colour_t c;
    case (band)
      4'd0:    c = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
      4'd1:    c = '{blue: 8'd0,   green: 8'd128, red: 8'd255};
      4'd2:    c = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
      4'd3:    c = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
      4'd4:    c = '{blue: 8'd100, green: 8'd255, red: 8'd0};
      4'd5:    c = '{blue: 8'd200, green: 8'd255, red: 8'd0};
      4'd6:    c = '{blue: 8'd255, green: 8'd255, red: 8'd0};
      4'd7:    c = '{blue: 8'd255, green: 8'd128, red: 8'd0};
      default: c = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/flow_strain_rate_band_classifier.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_stall_o  | eight signed Q8.8 neighbour flows
// out     | output    | out_valid_o/out_stall_i| strain_peak_o, band_o, paint_o, colours
// cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_value_i
//
// One item per cycle sustained while out_stall_i is low. Four gradient and square
// stages, eighteen square-root cells of one root bit each, peak and band stages.
// Reset clears all pipeline valid bits and sets every threshold to zero.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles collapse and input is taken while a result waits at the output.
`default_nettype none
module flow_strain_rate_band_classifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [fsrb_pkg::FlowW-1:0]  above_vx_i,
  input  logic signed [fsrb_pkg::FlowW-1:0]  above_vy_i,
  input  logic signed [fsrb_pkg::FlowW-1:0]  below_vx_i,
  input  logic signed [fsrb_pkg::FlowW-1:0]  below_vy_i,
  input  logic signed [fsrb_pkg::FlowW-1:0]  left_vx_i,
  input  logic signed [fsrb_pkg::FlowW-1:0]  left_vy_i,
  input  logic signed [fsrb_pkg::FlowW-1:0]  right_vx_i,
  input  logic signed [fsrb_pkg::FlowW-1:0]  right_vy_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [fsrb_pkg::PeakW-1:0]         strain_peak_o,
  output logic [fsrb_pkg::BandW-1:0]         band_o,
  output logic                               paint_o,
  output logic [fsrb_pkg::ColW-1:0]          colour_blue_o,
  output logic [fsrb_pkg::ColW-1:0]          colour_green_o,
  output logic [fsrb_pkg::ColW-1:0]          colour_red_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fsrb_pkg::IdxW-1:0]          cfg_index_i,
  input  logic [fsrb_pkg::PeakW-1:0]         cfg_value_i
);
  import fsrb_pkg::*;

  thr_t    thr_q;
  flows_t  flows;
  colour_t colour;

  logic               grad_take, grad_valid;
  sq_t                grad_data;
  logic [NumCells:0]  cell_valid, cell_take;
  sq_t                cell_data [NumCells+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < IdxW'(NumBands))) begin
      thr_q[cfg_index_i[SelW-1:0]] <= cfg_value_i;
    end
  end

  assign flows = '{above_vx: above_vx_i, above_vy: above_vy_i,
                   below_vx: below_vx_i, below_vy: below_vy_i,
                   left_vx:  left_vx_i,  left_vy:  left_vy_i,
                   right_vx: right_vx_i, right_vy: right_vy_i};

  fsrb_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .flows_i (flows),
    .take_o  (grad_take),
    .valid_o (grad_valid),
    .data_o  (grad_data),
    .take_i  (cell_take[0])
  );

  assign in_stall_o    = !grad_take;
  assign cell_valid[0] = grad_valid;
  assign cell_data[0]  = grad_data;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    fsrb_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[i]),
      .data_i  (cell_data[i]),
      .take_o  (cell_take[i]),
      .valid_o (cell_valid[i+1]),
      .data_o  (cell_data[i+1]),
      .take_i  (cell_take[i+1])
    );
  end

  fsrb_band u_band (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cell_valid[NumCells]),
    .data_i   (cell_data[NumCells]),
    .take_o   (cell_take[NumCells]),
    .thr_i    (thr_q),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .peak_o   (strain_peak_o),
    .band_o   (band_o),
    .paint_o  (paint_o),
    .colour_o (colour)
  );

  assign colour_blue_o  = colour.blue;
  assign colour_green_o = colour.green;
  assign colour_red_o   = colour.red;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is free");

  a_band_exceeds_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && paint_o) |-> (strain_peak_o > thr_q[band_o[SelW-1:0]]))
    else $error("painted band threshold not exceeded");

  a_unpainted_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !paint_o) |->
      (colour_blue_o == '0 && colour_green_o == '0 && colour_red_o == '0))
    else $error("unpainted item carries a colour");

  a_no_lower_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !paint_o) |-> (strain_peak_o <= thr_q[0]))
    else $error("unpainted item exceeds first threshold");

endmodule
`default_nettype wire

// ===== sv/fsrb_grad.sv =====
`default_nettype none
module fsrb_grad (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  fsrb_pkg::flows_t flows_i,
  output logic            take_o,
  output logic            valid_o,
  output fsrb_pkg::sq_t   data_o,
  input  logic            take_i
);
  import fsrb_pkg::*;

  logic [GradStages-1:0] valid_q;
  logic [GradStages:0]   take;

  logic signed [DiffW-1:0] ga_d, gd_d, dbx, dry;
  logic signed [GradW-1:0] gb2_d;
  logic signed [DiffW-1:0] ga_q, gd_q;
  logic signed [GradW-1:0] gb2_q, gb2_s2_q;
  logic signed [GradW-1:0] tr_d, df_d, df_q, tr_neg;
  logic [TrW-1:0]          trabs_d, trabs_s2_q, trabs_s3_q, trabs_s4_q;
  logic signed [SqW-1:0]   dsq_d, bsq_d;
  logic [SqW-1:0]          dsq_q, bsq_q, rad_q;

  assign take[GradStages] = take_i;
  for (genvar k = 0; k < GradStages; k++) begin : g_take
    assign take[k] = !valid_q[k] || take[k+1];
  end
  assign take_o  = take[0];
  assign valid_o = valid_q[GradStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (take[0]) valid_q[0] <= valid_i;
      for (int k = 1; k < GradStages; k++) begin
        if (take[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_comb begin
    ga_d   = DiffW'(flows_i.right_vx) - DiffW'(flows_i.left_vx);
    gd_d   = DiffW'(flows_i.above_vy) - DiffW'(flows_i.below_vy);
    dbx    = DiffW'(flows_i.above_vx) - DiffW'(flows_i.below_vx);
    dry    = DiffW'(flows_i.right_vy) - DiffW'(flows_i.left_vy);
    gb2_d  = GradW'(dbx) + GradW'(dry);
    tr_d   = GradW'(ga_q) + GradW'(gd_q);
    df_d   = GradW'(ga_q) - GradW'(gd_q);
    tr_neg = -tr_d;
    trabs_d = tr_d[GradW-1] ? tr_neg[TrW-1:0] : tr_d[TrW-1:0];
    dsq_d  = df_q * df_q;
    bsq_d  = gb2_s2_q * gb2_s2_q;
  end

  always_ff @(posedge clk_i) begin
    if (take[0]) begin
      ga_q  <= ga_d;
      gd_q  <= gd_d;
      gb2_q <= gb2_d;
    end
    if (take[1]) begin
      df_q       <= df_d;
      gb2_s2_q   <= gb2_q;
      trabs_s2_q <= trabs_d;
    end
    if (take[2]) begin
      dsq_q      <= SqW'(dsq_d);
      bsq_q      <= SqW'(bsq_d);
      trabs_s3_q <= trabs_s2_q;
    end
    if (take[3]) begin
      rad_q      <= dsq_q + bsq_q;
      trabs_s4_q <= trabs_s3_q;
    end
  end

  assign data_o = '{rad: rad_q, rem: '0, root: '0, trabs: trabs_s4_q};

endmodule
`default_nettype wire

// ===== sv/fsrb_sqrt_cell.sv =====
`default_nettype none
module fsrb_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  fsrb_pkg::sq_t data_i,
  output logic          take_o,
  output logic          valid_o,
  output fsrb_pkg::sq_t data_o,
  input  logic          take_i
);
  import fsrb_pkg::*;

  logic      valid_q;
  sq_t       data_q, data_d;
  logic [RemW-1:0] rem_w, trial;
  logic      fits;

  assign take_o  = !valid_q || take_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    rem_w = {data_i.rem[RemW-3:0], data_i.rad[SqW-1 -: 2]};
    trial = {data_i.root, 2'b01};
    fits  = rem_w >= trial;
    data_d.rad   = {data_i.rad[SqW-3:0], 2'b00};
    data_d.rem   = fits ? (rem_w - trial) : rem_w;
    data_d.root  = {data_i.root[RootW-2:0], fits};
    data_d.trabs = data_i.trabs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) data_q <= data_d;
  end

endmodule
`default_nettype wire

// ===== sv/fsrb_band.sv =====
`default_nettype none
module fsrb_band (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  fsrb_pkg::sq_t                 data_i,
  output logic                          take_o,
  input  fsrb_pkg::thr_t                thr_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [fsrb_pkg::PeakW-1:0]    peak_o,
  output logic [fsrb_pkg::BandW-1:0]    band_o,
  output logic                          paint_o,
  output fsrb_pkg::colour_t             colour_o
);
  import fsrb_pkg::*;

  logic             pk_valid_q, out_valid_q;
  logic             pk_take, out_take;
  logic [PeakW:0]   sum_d;
  logic [PeakW-1:0] peak_q, peak_out_q;
  logic [BandW-1:0] band_d, band_q;

  assign out_take = !out_valid_q || !stall_i;
  assign pk_take  = !pk_valid_q || out_take;
  assign take_o   = pk_take;

  always_comb begin
    sum_d  = (PeakW+1)'(data_i.trabs) + (PeakW+1)'(data_i.root);
    band_d = BandNone;
    for (int k = NumBands - 1; k >= 0; k--) begin
      if (peak_q > thr_i[k]) band_d = BandW'(k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pk_take)  pk_valid_q  <= valid_i;
      if (out_take) out_valid_q <= pk_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pk_take) peak_q <= sum_d[PeakW:1];
    if (out_take) begin
      peak_out_q <= peak_q;
      band_q     <= band_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign peak_o   = peak_out_q;
  assign band_o   = band_q;
  assign paint_o  = band_q != BandNone;
  assign colour_o = band_colour(band_q);

endmodule
`default_nettype wire
